// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

  localparam int unsigned FRAME_NODES    = 256;
  localparam int unsigned MAX_PER_PACKET = 128;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READINGS = 1'b1;

  localparam logic [7:0] SRC_ID_RST   = 8'd1;
  localparam logic [7:0] READINGS_RST = 8'd64;

  localparam logic [7:0] DELIM_W = 8'h77;  // 'w'
  localparam logic [7:0] DELIM_R = 8'h72;  // 'r'

  // one bit per packet size: set when nonzero, within the max and a divisor of the frame
  function automatic logic [255:0] size_ok_table();
    logic [255:0] tbl;
    tbl = '0;
    for (int d = 1; d < 256; d++) begin
      if (d <= int'(MAX_PER_PACKET)) begin
        for (int m = d; m <= int'(FRAME_NODES); m += d) begin
          if (m == int'(FRAME_NODES)) tbl[d] = 1'b1;
        end
      end
    end
    return tbl;
  endfunction

  localparam logic [255:0] SIZE_OK = size_ok_table();

  // one classified reading, handed from front to back
  typedef struct packed {
    logic        err;
    logic        hdr;
    logic        trl;
    logic [7:0]  src_id;
    logic [15:0] frame_pos;
    logic [15:0] reading;
    logic [31:0] pkt_num;
  } job_t;

  typedef enum logic [3:0] {
    S_START,
    S_ID,
    S_POS_LO,
    S_POS_HI,
    S_RD_LO,
    S_RD_HI,
    S_PK0,
    S_PK1,
    S_PK2,
    S_PK3,
    S_DLM_W,
    S_DLM_R,
    S_ERR
  } step_t;

endpackage

// ===== rtl/sfp_front.sv =====
module sfp_front import sfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 push,
  input  logic [15:0]          reading,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job
);

  logic [7:0]  src_id_r;
  logic [7:0]  readings_r;
  logic [15:0] frame_pos_r, frame_pos_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [31:0] pkt_num_r, pkt_num_nxt;

  logic        size_ok;
  logic        accept;
  logic        trl;
  logic [16:0] pos_inc;
  logic [8:0]  fill_inc;

  assign size_ok  = SIZE_OK[readings_r];
  assign accept   = push && !q_full;
  assign pos_inc  = {1'b0, frame_pos_r} + 17'd1;
  assign fill_inc = {1'b0, fill_r} + 9'd1;
  // packet closes once fill reaches the current size, even if the size shrank
  assign trl      = fill_inc >= {1'b0, readings_r};

  always_comb begin
    frame_pos_nxt = frame_pos_r;
    fill_nxt      = fill_r;
    pkt_num_nxt   = pkt_num_r;
    if (accept && size_ok) begin
      frame_pos_nxt = (pos_inc >= 17'(FRAME_NODES)) ? 16'd0 : pos_inc[15:0];
      if (trl) begin
        fill_nxt    = 8'd0;
        pkt_num_nxt = pkt_num_r + 32'd1;
      end else begin
        fill_nxt = fill_inc[7:0];
      end
    end
  end

  always_comb begin
    q_push          = accept;
    q_job.err       = !size_ok;
    q_job.hdr       = (fill_r == 8'd0);
    q_job.trl       = trl;
    q_job.src_id    = src_id_r;
    q_job.frame_pos = frame_pos_r;
    q_job.reading   = reading;
    q_job.pkt_num   = pkt_num_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_id_r    <= SRC_ID_RST;
      readings_r  <= READINGS_RST;
      frame_pos_r <= '0;
      fill_r      <= '0;
      pkt_num_r   <= '0;
    end else begin
      frame_pos_r <= frame_pos_nxt;
      fill_r      <= fill_nxt;
      pkt_num_r   <= pkt_num_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SRC_ID:   src_id_r   <= cfg_data;
          CFG_READINGS: readings_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/sfp_queue.sv =====
module sfp_queue import sfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count_r != '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

// ===== rtl/sfp_back.sv =====
module sfp_back import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_avail,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_data_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_packet,
  output logic       out_config_error
);

  step_t step_r, step_nxt, cur;
  logic  adv;
  logic  last;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, eop_r, err_r;

  logic [7:0] byte_c;
  logic       eop_c;

  // a job opens on error, header or reading low byte
  always_comb begin
    if (step_r == S_START) begin
      if (q_head.err)      cur = S_ERR;
      else if (q_head.hdr) cur = S_ID;
      else                 cur = S_RD_LO;
    end else begin
      cur = step_r;
    end
  end

  assign adv   = q_avail && (!valid_r || out_pop);
  assign q_pop = adv && last;

  // next state
  always_comb begin
    step_nxt = step_r;
    if (adv) begin
      unique case (cur)
        S_ID:     step_nxt = S_POS_LO;
        S_POS_LO: step_nxt = S_POS_HI;
        S_POS_HI: step_nxt = S_RD_LO;
        S_RD_LO:  step_nxt = S_RD_HI;
        S_RD_HI:  step_nxt = q_head.trl ? S_PK0 : S_START;
        S_PK0:    step_nxt = S_PK1;
        S_PK1:    step_nxt = S_PK2;
        S_PK2:    step_nxt = S_PK3;
        S_PK3:    step_nxt = S_DLM_W;
        S_DLM_W:  step_nxt = S_DLM_R;
        default:  step_nxt = S_START;
      endcase
    end
  end

  // outputs
  always_comb begin
    byte_c = 8'd0;
    eop_c  = 1'b0;
    last   = 1'b0;
    unique case (cur)
      S_ID:     byte_c = q_head.src_id;
      S_POS_LO: byte_c = q_head.frame_pos[7:0];
      S_POS_HI: byte_c = q_head.frame_pos[15:8];
      S_RD_LO:  byte_c = q_head.reading[7:0];
      S_RD_HI: begin
        byte_c = q_head.reading[15:8];
        last   = !q_head.trl;
      end
      S_PK0:    byte_c = q_head.pkt_num[7:0];
      S_PK1:    byte_c = q_head.pkt_num[15:8];
      S_PK2:    byte_c = q_head.pkt_num[23:16];
      S_PK3:    byte_c = q_head.pkt_num[31:24];
      S_DLM_W:  byte_c = DELIM_W;
      S_DLM_R: begin
        byte_c = DELIM_R;
        eop_c  = 1'b1;
        last   = 1'b1;
      end
      S_ERR:    last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= S_START;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (adv)          valid_r <= 1'b1;
      else if (out_pop) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= byte_c;
      last_r <= last;
      eop_r  <= eop_c;
      err_r  <= (cur == S_ERR);
    end
  end

  assign out_empty         = !valid_r;
  assign out_data_byte     = byte_r;
  assign out_last_of_run   = last_r;
  assign out_end_of_packet = eop_r;
  assign out_config_error  = err_r;

endmodule

// ===== rtl/sensor_frame_packetizer.sv =====
// channel  | direction | handshake         | words
// in_      | input     | in_push / in_full | in_reading (16 bits)
// out_     | output    | out_pop / out_empty | data_byte, last_of_run, end_of_packet,
//          |           |                   | config_error
// cfg_     | input     | cfg_valid / cfg_ready | cfg_index (0 sensor id, 1 readings), cfg_data
//
// a reading becomes 2, 5, 8 or 11 output words (1 word when the packet size is bad);
// the byte sequencer in the back end emits one word per cycle while a job is queued
// and the output word has been popped or is empty.
// a pushed reading passes the job queue, then the output register, before its first word shows.
// reset is synchronous, active low; state, queue pointers and output valid flag are cleared.
// in_full rises when the 2-entry job queue is full; out_pop low stalls the sequencer only.
module sensor_frame_packetizer import sfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [15:0]          in_reading,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_data_byte,
  output logic                 out_last_of_run,
  output logic                 out_end_of_packet,
  output logic                 out_config_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic q_push, q_full, q_pop, q_avail;
  job_t q_job, q_head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  sfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (in_push),
    .reading   (in_reading),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  sfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  sfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_avail           (q_avail),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_data_byte     (out_data_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_packet (out_end_of_packet),
    .out_config_error  (out_config_error)
  );

endmodule

// ===== rtl/sfp_checker.sv =====
module sfp_checker import sfp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_data_byte,
  input logic       out_last_of_run,
  input logic       out_end_of_packet,
  input logic       out_config_error
);

  // nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // input side is open right after reset
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // an error word stands alone and carries no byte
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_config_error) |->
      (out_last_of_run && !out_end_of_packet && out_data_byte == 8'd0))
    else $error("malformed error word");

  // closing delimiter ends the run
  a_eop_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_end_of_packet) |->
      (out_last_of_run && out_data_byte == DELIM_R && !out_config_error))
    else $error("malformed closing delimiter");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data_byte)))
    else $error("stalled word changed");

endmodule

bind sensor_frame_packetizer sfp_checker u_sfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_data_byte     (out_data_byte),
  .out_last_of_run   (out_last_of_run),
  .out_end_of_packet (out_end_of_packet),
  .out_config_error  (out_config_error)
);
